>>> hw/rtl/tmpu_pkg.sv
// Shared types, constants and helpers for the trapezoid motion profile unit.
package tmpu_pkg;

  localparam int PosW   = 32;
  localparam int AccW   = 31;
  localparam int TickW  = 16;
  localparam int PhaseW = 2;
  localparam int CfgIdxW = 2;
  localparam int ProdW  = PosW + TickW;   // velocity * tick product width

  localparam logic [AccW-1:0]  AccelRateRst     = AccW'(65536);
  localparam logic [AccW-1:0]  VelocityLimitRst = AccW'(65536);
  localparam logic [TickW-1:0] TickSecondsRst   = TickW'(655);

  localparam logic ModeStart = 1'b0;
  localparam logic ModeTick  = 1'b1;

  typedef enum logic [PhaseW-1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VEL,
    ST_PMUL,
    ST_POS
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_RATE     = 2'd0,
    CFG_VELOCITY_LIMIT = 2'd1,
    CFG_TICK_SECONDS   = 2'd2
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load_start;  // latch a new move from the input beat
    logic mul_dv;      // register accel * tick
    logic step_vel;    // phase decision and velocity update
    logic mul_pos;     // register velocity * tick
    logic step_pos;    // position update, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic moving;
  } status_t;

  // clamp a 34-bit signed value to the signed 32-bit range
  function automatic logic [PosW-1:0] sat_s32(input logic [PosW+1:0] v);
    logic [PosW-1:0] r;
    if ((v[PosW+1] == v[PosW]) && (v[PosW] == v[PosW-1])) begin
      r = v[PosW-1:0];
    end else if (v[PosW+1]) begin
      r = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PosW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tmpu_ctrl.sv
// Sequencing state machine for the trapezoid motion profile unit.
module tmpu_ctrl import tmpu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    mode_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pos_go;
  cmd_t   cmd;

  // position step may commit once the result register is free or draining
  assign pos_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == ModeTick) && status_i.moving) begin
          state_d = ST_VEL;
        end
      end
      ST_VEL:  state_d = ST_PMUL;
      ST_PMUL: state_d = ST_POS;
      ST_POS: begin
        if (pos_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd.load_start = in_valid_i && (mode_i == ModeStart);
        cmd.mul_dv     = in_valid_i && (mode_i == ModeTick) && status_i.moving;
      end
      ST_VEL:  cmd.step_vel = 1'b1;
      ST_PMUL: cmd.mul_pos  = 1'b1;
      ST_POS:  cmd.step_pos = pos_go;
      default: cmd = '0;
    endcase
  end

  assign out_valid_d = cmd.step_pos || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/tmpu_dp.sv
// Datapath: config registers, motion state, multipliers and result register.
module tmpu_dp import tmpu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic                      cfg_we_i,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [AccW-1:0]    cfg_data_i,
  input  logic signed [PosW-1:0]    start_pos_i,
  input  logic signed [PosW-1:0]    end_pos_i,
  output logic signed [PosW-1:0]    position_o,
  output logic        [PhaseW-1:0]  phase_o,
  output logic                      last_o
);

  // config
  logic [AccW-1:0]  accel_q, vlim_q;
  logic [TickW-1:0] tick_q;

  // motion state
  logic [PosW-1:0] pos_q, vel_q, origin_q, target_q, ramp_q;
  phase_e          phase_q;
  logic            moving_q;

  // pipeline registers
  logic [AccW-1:0]         dv_q, dv_d;
  logic signed [ProdW-1:0] pm_q, pm_d;

  // result register
  logic [PosW-1:0]   res_pos_q;
  logic [PhaseW-1:0] res_phase_q;
  logic              res_last_q;

  logic [AccW+TickW-1:0] dv_prod;
  logic [PosW+1:0]       vel_ext, dv_ext, pos_sum, remain;
  logic [PosW-1:0]       vel_up, vel_dn, vel_d, ramp_d, pos_d;
  logic [PosW:0]         span, mid, pos33;
  logic                  reach, near, last_d;
  phase_e                phase_d;

  // velocity increment, exact product truncated
  assign dv_prod = accel_q * tick_q;
  assign dv_d    = dv_prod[AccW+TickW-1:TickW];

  assign vel_ext = {{2{vel_q[PosW-1]}}, vel_q};
  assign dv_ext  = {3'b000, dv_q};
  assign vel_up  = sat_s32(vel_ext + dv_ext);
  assign vel_dn  = sat_s32(vel_ext - dv_ext);

  // midpoint; span is never negative while moving
  assign span  = {target_q[PosW-1], target_q} - {origin_q[PosW-1], origin_q};
  assign mid   = {origin_q[PosW-1], origin_q} + {1'b0, span[PosW:1]};
  assign pos33 = {pos_q[PosW-1], pos_q};
  assign reach = ($signed(vel_up) >= $signed({1'b0, vlim_q})) ||
                 ($signed(pos33) >= $signed(mid));

  assign remain = {{2{target_q[PosW-1]}}, target_q} - {{2{pos_q[PosW-1]}}, pos_q};
  assign near   = $signed(remain) <= $signed({2'b00, ramp_q});

  always_comb begin
    vel_d   = vel_q;
    phase_d = phase_q;
    ramp_d  = ramp_q;
    unique case (phase_q)
      PH_ACCEL: begin
        vel_d = vel_up;
        if (reach) begin
          ramp_d  = pos_q - origin_q;
          phase_d = PH_CRUISE;
        end
      end
      PH_CRUISE: begin
        if (near) begin
          phase_d = PH_DECEL;
        end
      end
      default: vel_d = vel_dn;
    endcase
  end

  // position increment, floor via arithmetic shift of the product
  assign pm_d    = $signed(vel_q) * $signed({1'b0, tick_q});
  assign pos_sum = {{2{pos_q[PosW-1]}}, pos_q} +
                   {{2{pm_q[ProdW-1]}}, pm_q[ProdW-1:TickW]};
  assign pos_d   = sat_s32(pos_sum);
  assign last_d  = ($signed(pos_d) > $signed(target_q)) || vel_q[PosW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= AccelRateRst;
      vlim_q  <= VelocityLimitRst;
      tick_q  <= TickSecondsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACCEL_RATE:     accel_q <= cfg_data_i;
        CFG_VELOCITY_LIMIT: vlim_q  <= cfg_data_i;
        CFG_TICK_SECONDS:   tick_q  <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      vel_q    <= '0;
      origin_q <= '0;
      target_q <= '0;
      ramp_q   <= '0;
      phase_q  <= PH_ACCEL;
      moving_q <= 1'b0;
    end else if (cmd_i.load_start) begin
      origin_q <= start_pos_i;
      target_q <= end_pos_i;
      pos_q    <= start_pos_i;
      vel_q    <= '0;
      ramp_q   <= '0;
      phase_q  <= PH_ACCEL;
      moving_q <= (start_pos_i <= end_pos_i);
    end else if (cmd_i.step_vel) begin
      vel_q   <= vel_d;
      phase_q <= phase_d;
      ramp_q  <= ramp_d;
    end else if (cmd_i.step_pos) begin
      pos_q <= pos_d;
      if (last_d) begin
        moving_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_dv) begin
      dv_q <= dv_d;
    end
    if (cmd_i.mul_pos) begin
      pm_q <= pm_d;
    end
    if (cmd_i.step_pos) begin
      res_pos_q   <= pos_d;
      res_phase_q <= phase_q;
      res_last_q  <= last_d;
    end
  end

  assign status_o.moving = moving_q;
  assign position_o      = res_pos_q;
  assign phase_o         = res_phase_q;
  assign last_o          = res_last_q;

endmodule

>>> hw/rtl/trapezoid_motion_profile_unit.sv
// Top level of the single-axis trapezoidal setpoint generator (Q16.16).
//
//  channel   direction  handshake               payload
//  ---------------------------------------------------------------------------
//  in        sink       in_valid_i / in_ready_o  mode_i, start_pos_i, end_pos_i
//  out       source     out_valid_o/out_ready_i  position_o, phase_o, last_o
//  cfg       sink       cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
//  Sequence: a tick beat of a moving axis runs the steps accept (accel*tick)
//  -> velocity -> velocity*tick -> position, and the next beat is not taken
//  until the last step is done. Start beats and idle ticks finish on accept.
//  Reset: asynchronous, active low; config returns to its defaults and the
//  axis goes idle in the accelerate phase with its motion state zeroed.
//  Stalls: the result register lets the next beat be accepted while a result
//  waits; a tick only holds in its last step if the previous result is still
//  unclaimed.
module trapezoid_motion_profile_unit import tmpu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input beats
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic signed [PosW-1:0]    start_pos_i,
  input  logic signed [PosW-1:0]    end_pos_i,
  // result beats
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [PosW-1:0]    position_o,
  output logic        [PhaseW-1:0]  phase_o,
  output logic                      last_o,
  // config writes
  input  logic                      cfg_we_i,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [AccW-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // sequencing: decides which datapath step runs each cycle
  tmpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, motion state and the result register
  tmpu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_pos_i (start_pos_i),
    .end_pos_i   (end_pos_i),
    .position_o  (position_o),
    .phase_o     (phase_o),
    .last_o      (last_o)
  );

endmodule

>>> hw/rtl/tmpu_checker.sv
// Port-level assertions for the trapezoid motion profile unit, with bind.
module tmpu_checker import tmpu_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     mode_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [PosW-1:0]   position_o,
  input logic        [PhaseW-1:0] phase_o,
  input logic                     last_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(position_o) && $stable(phase_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // a fresh result must follow an accepted tick beat, which passes the
  // velocity, multiply and position states before the result is driven
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (mode_i == ModeTick), 4))
    else $error("result beat without matching tick beat");

  // a start beat never produces a result
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == ModeStart) |=> !$rose(out_valid_o))
    else $error("start beat produced a result");

  // reported phase is a legal code
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o == PH_ACCEL) || (phase_o == PH_CRUISE) ||
                    (phase_o == PH_DECEL))
    else $error("illegal phase on result beat");

endmodule

bind trapezoid_motion_profile_unit tmpu_checker u_tmpu_checker (.*);

>>> tb/trapezoid_motion_profile_unit_test.sv
// Self-checking testbench for the trapezoid motion profile unit: directed table, then random moves.
`timescale 1ns / 1ps

module trapezoid_motion_profile_unit_test;
  import tmpu_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants and types
  // ---------------------------------------------------------------------------
  localparam int          RandomBeats  = 1400;     // starts plus ticks that give a result
  localparam int          DrainCycles  = 8;        // lets a trailing tick finish; margin on top
  localparam int          TickCap      = 80;       // give up on a move after this many ticks
  localparam int          MaxReports   = 10;
  localparam longint      S32Max       = 64'sd2147483647;
  localparam longint      S32Min       = -64'sd2147483648;
  localparam logic [31:0] PosMax       = 32'h7FFF_FFFF;
  localparam logic [31:0] PosMin       = 32'h8000_0000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;   // no register behind it

  typedef struct packed {
    logic signed [PosW-1:0] position;
    phase_e                 phase;
    logic                   last;
  } setpoint_t;

  localparam setpoint_t NoResult = '0;

  typedef enum logic [1:0] {
    ROW_BEAT,    // one input beat
    ROW_CFG,     // register write, arg_a = index, arg_b = data
    ROW_DRAIN    // hold the sender until every result is back
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
    logic        fixed_exp;    // 1: use the result typed in below, not the predictor
    logic        has_result;
    setpoint_t   result;
  } stim_row_t;

  // Directed part. Typed results only where they are obvious: start beats, idle
  // ticks, descending moves, and the zero-length move at reset settings
  // (v = 655, step = 655*655 >> 16 = 6, past the end at once).
  localparam int NumDirRows = 35;
  localparam stim_row_t DirTable [NumDirRows] = '{
    // idle after reset: tick is dropped
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b1, 1'b0, NoResult},
    // descending move never starts
    '{ROW_BEAT,  ModeStart, 32'h4000_0000, 32'h3FFF_FFFF, 1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, NoResult},
    // zero-length move: one sample, cruise, last
    '{ROW_BEAT,  ModeStart, 32'h0,        32'h0,        1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b1, 1'b1,
      '{32'sd6, PH_CRUISE, 1'b1}},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b1, 1'b0, NoResult},
    // pinned at the top of the range: position saturates, velocity goes negative
    '{ROW_BEAT,  ModeStart, PosMax,       PosMax,       1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_DRAIN, ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    // full-range move, abandoned by the next start
    '{ROW_BEAT,  ModeStart, PosMin,       PosMax,       1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, NoResult},
    // short move through all three phases: accel 100.0, limit 2.0
    '{ROW_CFG,   ModeTick,  32'(CFG_ACCEL_RATE),     32'h0064_0000, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,   ModeTick,  32'(CFG_VELOCITY_LIMIT), 32'h0002_0000, 1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeStart, 32'hFFFF_0000, 32'hFFFF_1999, 1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    // every register at its top; accel data has bit 31 set, which is dropped
    '{ROW_CFG,   ModeTick,  32'(CFG_ACCEL_RATE),     32'hFFFF_FFFF, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,   ModeTick,  32'(CFG_VELOCITY_LIMIT), 32'h7FFF_FFFF, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,   ModeTick,  32'(CFG_TICK_SECONDS),   32'h0000_FFFF, 1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeStart, PosMin,       32'h8001_0000, 1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    // zero tick (upper bits masked off), spare index ignored: the axis never moves
    '{ROW_CFG,   ModeTick,  32'(CFG_TICK_SECONDS),   32'h0001_0000, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,   ModeTick,  32'(CfgIdxSpare),        32'hFFFF_FFFF, 1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeStart, 32'h0,        32'h0001_0000, 1'b1, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult},
    '{ROW_BEAT,  ModeTick,  32'h0,        32'h0,        1'b0, 1'b0, NoResult}
  };

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     mode_i;
  logic signed [PosW-1:0]   start_pos_i;
  logic signed [PosW-1:0]   end_pos_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [PosW-1:0]   position_o;
  logic        [PhaseW-1:0] phase_o;
  logic                     last_o;
  logic                     cfg_we_i;
  logic        [CfgIdxW-1:0] cfg_index_i;
  logic        [AccW-1:0]   cfg_data_i;

  trapezoid_motion_profile_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .start_pos_i (start_pos_i),
    .end_pos_i   (end_pos_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .phase_o     (phase_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Profile predictor: own copy of config and axis state
  // ---------------------------------------------------------------------------
  logic [AccW-1:0]        c_accel  = AccelRateRst;
  logic [AccW-1:0]        c_vlimit = VelocityLimitRst;
  logic [TickW-1:0]       c_tick   = TickSecondsRst;

  logic signed [PosW-1:0] p_pos    = '0;
  logic signed [PosW-1:0] p_vel    = '0;
  logic signed [PosW-1:0] p_origin = '0;
  logic signed [PosW-1:0] p_target = '0;
  logic        [PosW-1:0] p_ramp   = '0;   // distance from origin, unsigned
  phase_e                 p_phase  = PH_ACCEL;
  logic                   p_moving = 1'b0;

  setpoint_t setpoint_q [$];   // results still owed by the block

  function automatic longint clamp32(input longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // One input beat; returns 1 when it yields a setpoint.
  function automatic bit next_setpoint(input logic m, input logic signed [PosW-1:0] s,
                                       input logic signed [PosW-1:0] e,
                                       output setpoint_t r);
    longint dv;
    longint x;
    longint v;
    longint mid;
    logic   fin;
    r = NoResult;
    if (m == ModeStart) begin
      p_origin = s;
      p_target = e;
      p_pos    = s;
      p_vel    = '0;
      p_ramp   = '0;
      p_phase  = PH_ACCEL;
      p_moving = (s <= e);
      return 1'b0;
    end
    if (!p_moving) return 1'b0;

    dv = (longint'(c_accel) * longint'(c_tick)) >>> 16;
    x  = longint'(p_pos);
    v  = longint'(p_vel);

    case (p_phase)
      PH_ACCEL: begin
        mid = longint'(p_origin) + (longint'(p_target) - longint'(p_origin)) / 2;
        v = clamp32(v + dv);
        if (v >= longint'(c_vlimit) || x >= mid) begin
          p_ramp  = 32'(x - longint'(p_origin));   // ramp kept relative to origin
          p_phase = PH_CRUISE;
        end
      end
      PH_CRUISE: begin
        if (longint'(p_target) - x <= longint'(p_ramp)) p_phase = PH_DECEL;
      end
      default: begin
        v = clamp32(v - dv);
      end
    endcase

    // arithmetic shift floors toward minus infinity
    x = clamp32(x + ((v * longint'(c_tick)) >>> 16));
    p_vel = 32'(v);
    p_pos = 32'(x);
    fin = (x > longint'(p_target)) || (v < 0);
    if (fin) p_moving = 1'b0;

    r.position = p_pos;
    r.phase    = p_phase;
    r.last     = fin;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  int err_count  = 0;
  int n_start    = 0;
  int n_tick_res = 0;
  int n_ignored  = 0;
  int n_results  = 0;
  int n_finished = 0;
  int n_phases   = 0;

  // set by the sender along with each beat
  logic      beat_fixed = 1'b0;
  logic      fixed_has  = 1'b0;
  setpoint_t fixed_res  = NoResult;

  logic no_idle  = 1'b0;   // stretch with no gaps on either side
  int   stall_left = 0;

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= MaxReports) $display("mismatch: %s", msg);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: predict on every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    setpoint_t sp;
    bit        got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      got = next_setpoint(mode_i, start_pos_i, end_pos_i, sp);
      if (beat_fixed) begin
        got = fixed_has;
        sp  = fixed_res;
      end
      if (mode_i == ModeStart) n_start++;
      else if (got) n_tick_res++;
      else n_ignored++;
      if (got) begin
        setpoint_q.insert(setpoint_q.size(), sp);
        if (sp.last) n_finished++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, compare each result beat
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    setpoint_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (setpoint_q.size() == 0) begin
        note_failure($sformatf("result with nothing expected: pos=%0d phase=%0d last=%0b",
                               position_o, phase_o, last_o));
      end else begin
        want = setpoint_q.pop_front();
        if (position_o !== want.position || phase_o !== want.phase ||
            last_o !== want.last) begin
          note_failure($sformatf(
            "result %0d: expected pos=%0d phase=%0d last=%0b, got pos=%0d phase=%0d last=%0b",
            n_results, $signed(want.position), want.phase, want.last,
            position_o, phase_o, last_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic m, input logic [PosW-1:0] s, input logic [PosW-1:0] e);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    start_pos_i <= s;
    end_pos_i   <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off until every owed result is back, then let a trailing tick or
  // start beat finish inside the block.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (setpoint_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Leaves cfg_we_i high; the caller lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[AccW-1:0];
    case (idx)
      CFG_ACCEL_RATE:     c_accel  = data[AccW-1:0];
      CFG_VELOCITY_LIMIT: c_vlimit = data[AccW-1:0];
      CFG_TICK_SECONDS:   c_tick   = data[TickW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // New register set for one random phase; block must be idle.
  task automatic pick_config();
    logic [31:0] a;
    logic [31:0] l;
    logic [31:0] t;
    longint      dv;
    case ($urandom_range(0, 5))
      0: begin   // reset values
        a = 32'(AccelRateRst);
        l = 32'(VelocityLimitRst);
        t = 32'(TickSecondsRst);
      end
      1: begin   // everything at the top
        a = PosMax;
        l = PosMax;
        t = 32'h0000_FFFF;
      end
      2: begin   // crawl: no velocity, immediate cruise, moves never end
        a = $urandom_range(0, 1);
        l = 32'h0;
        t = 32'h1;
      end
      3: begin   // raw bits; upper bits are dropped, tick may come out zero
        a = $urandom;
        l = $urandom;
        t = $urandom;
      end
      default: begin   // scaled so a move takes a few dozen ticks
        a  = $urandom >> $urandom_range(1, 20);
        t  = $urandom_range(1, 65535) >> $urandom_range(0, 10);
        if (t == 0) t = 1;
        dv = (longint'(a[AccW-1:0]) * longint'(t)) >>> 16;
        dv = dv * $urandom_range(1, 30);
        l  = (dv > S32Max) ? PosMax : 32'(dv);
      end
    endcase
    write_reg(CFG_ACCEL_RATE, a);
    write_reg(CFG_VELOCITY_LIMIT, l);
    write_reg(CFG_TICK_SECONDS, t);
    if ($urandom_range(0, 3) == 0) write_reg(CfgIdxSpare, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // One move: start beat, then ticks until the last sample or the cap.
  task automatic run_move();
    longint                 stride;
    longint                 span;
    logic signed [PosW-1:0] s;
    logic signed [PosW-1:0] e;
    logic signed [PosW-1:0] tmp;
    int                     kind;
    int                     cap;
    int                     ticks;
    kind   = $urandom_range(0, 19);
    s      = $urandom;
    // distance covered in one tick at one tick's worth of velocity
    stride = (((longint'(c_accel) * longint'(c_tick)) >>> 16) * longint'(c_tick)) >>> 16;
    if (stride < 1) stride = 1;
    span = stride * $urandom_range(0, 300);
    if (kind == 0) begin
      e = $urandom;                      // arbitrary pair, either direction
    end else if (kind == 1) begin
      e = $urandom;                      // forced descending
      if (s < e) begin
        tmp = s;
        s   = e;
        e   = tmp;
      end
    end else begin
      e = 32'(clamp32(longint'(s) + span));
    end
    send_beat(ModeStart, s, e);

    // now and then cut a move short with the next start
    cap   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 10) : TickCap;
    ticks = 0;
    while (p_moving && ticks < cap) begin
      send_beat(ModeTick, $urandom, $urandom);
      ticks++;
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
    // stray ticks on an idle axis
    if (!p_moving && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) send_beat(ModeTick, $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    int phase_goal;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = ModeTick;
    start_pos_i = '0;
    end_pos_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_ACCEL_RATE;
    cfg_data_i  = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed table
    for (int i = 0; i < NumDirRows; i++) begin
      case (DirTable[i].kind)
        ROW_BEAT: begin
          beat_fixed = DirTable[i].fixed_exp;
          fixed_has  = DirTable[i].has_result;
          fixed_res  = DirTable[i].result;
          send_beat(DirTable[i].mode, DirTable[i].arg_a, DirTable[i].arg_b);
        end
        ROW_CFG: begin
          wait_drained();
          write_reg(DirTable[i].arg_a[CfgIdxW-1:0], DirTable[i].arg_b);
          cfg_we_i <= 1'b0;
        end
        default: begin
          wait_drained();
        end
      endcase
    end
    beat_fixed = 1'b0;

    // random phases, each with its own register set
    base = n_start + n_tick_res;
    while (n_start + n_tick_res - base < RandomBeats) begin
      wait_drained();
      pick_config();
      no_idle    = ($urandom_range(0, 4) == 0);
      phase_goal = n_start + n_tick_res + $urandom_range(60, 200);
      while (n_start + n_tick_res < phase_goal) run_move();
      n_phases++;
    end

    wait_drained();
    if (setpoint_q.size() != 0) note_failure("results still owed at the end");

    $display("ran %0d start beats, %0d ticks with a setpoint, %0d ignored beats",
             n_start, n_tick_res, n_ignored);
    $display("checked %0d setpoints over %0d register sets, %0d moves reached their end",
             n_results, n_phases, n_finished);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tmpu_pkg.sv
hw/rtl/tmpu_ctrl.sv
hw/rtl/tmpu_dp.sv
hw/rtl/trapezoid_motion_profile_unit.sv
hw/rtl/tmpu_checker.sv
tb/trapezoid_motion_profile_unit_test.sv
